// ===== src/gdd_pkg.sv =====
// ----------------------------------------------------------------------------
// gdd_pkg: shared types and constants for the Gregorian day difference unit
// Holds the item structs, the calendar tables and the constant-divide
// parameters that the date converter and the top level both use.
// ----------------------------------------------------------------------------
package gdd_pkg;

  // Default upper bound of a valid year.
  localparam int unsigned MAX_YEAR_DEF = 9999;

  // Division by 100 as a multiply by a rounded-up reciprocal and a shift.
  // The result is exact for every 14-bit operand.
  localparam int unsigned DIV100_MUL   = 5243;
  localparam int unsigned DIV100_SHIFT = 19;

  // Result saturation bounds of the 23-bit signed field.
  localparam logic signed [24:0] DIFF_MAX = 25'sd4194303;
  localparam logic signed [24:0] DIFF_MIN = -25'sd4194304;

  typedef struct packed {
    logic [4:0]  first_day;
    logic [3:0]  first_month;
    logic [13:0] first_year;
    logic [4:0]  second_day;
    logic [3:0]  second_month;
    logic [13:0] second_year;
    logic        include_end_day;
  } in_item_t;

  typedef struct packed {
    logic signed [22:0] day_difference;
    logic               date_invalid;
  } out_item_t;

  // Load enables of the two converter stages.
  typedef struct packed {
    logic a;
    logic b;
  } stg_en_t;

  // Converted date: the day number split into the year term and the rest.
  typedef struct packed {
    logic        ok;
    logic [22:0] year_days;
    logic [12:0] rest_days;
  } date_num_t;

  // Days in a month; zero for a month code that names no month.
  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
    logic [4:0] dim;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: dim = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    dim = 5'd30;
      4'd2:                                       dim = leap ? 5'd29 : 5'd28;
      default:                                    dim = 5'd0;
    endcase
    return dim;
  endfunction

  // Days before a month in a year that starts in March (index 0 is March).
  function automatic logic [8:0] month_offset(input logic [3:0] mi);
    logic [8:0] ofs;
    unique case (mi)
      4'd0:    ofs = 9'd0;
      4'd1:    ofs = 9'd31;
      4'd2:    ofs = 9'd61;
      4'd3:    ofs = 9'd92;
      4'd4:    ofs = 9'd122;
      4'd5:    ofs = 9'd153;
      4'd6:    ofs = 9'd184;
      4'd7:    ofs = 9'd214;
      4'd8:    ofs = 9'd245;
      4'd9:    ofs = 9'd275;
      4'd10:   ofs = 9'd306;
      4'd11:   ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

// ===== src/gdd_date_conv.sv =====
// ----------------------------------------------------------------------------
// gdd_date_conv: two-stage date checker and day-number converter
// Stage A takes the year apart (divisions by 100), stage B checks the date
// and forms the two halves of its day number.
// ----------------------------------------------------------------------------
module gdd_date_conv import gdd_pkg::*; #(
  parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic      clk,
  input  stg_en_t   en,
  input  logic [4:0]  day,
  input  logic [3:0]  month,
  input  logic [13:0] year,
  output date_num_t conv_r
);

  logic [4:0]  d_a_r;
  logic [3:0]  m_a_r;
  logic [13:0] y_a_r;
  logic [13:0] yy_a_r;
  logic [3:0]  mi_a_r;
  logic [7:0]  qy_a_r;
  logic [7:0]  qyy_a_r;

  logic        early;
  logic [13:0] yy_nxt;
  logic [3:0]  mi_nxt;
  logic [26:0] qy_prod;
  logic [26:0] qyy_prod;

  // January and February count as months 10 and 11 of the previous year.
  assign early    = (month < 4'd3);
  assign yy_nxt   = early ? year - 14'd1 : year;
  assign mi_nxt   = early ? month + 4'd9 : month - 4'd3;
  assign qy_prod  = 27'(year) * 27'(DIV100_MUL);
  assign qyy_prod = 27'(yy_nxt) * 27'(DIV100_MUL);

  always_ff @(posedge clk) begin
    if (en.a) begin
      d_a_r   <= day;
      m_a_r   <= month;
      y_a_r   <= year;
      yy_a_r  <= yy_nxt;
      mi_a_r  <= mi_nxt;
      qy_a_r  <= 8'(qy_prod >> DIV100_SHIFT);
      qyy_a_r <= 8'(qyy_prod >> DIV100_SHIFT);
    end
  end

  logic [14:0] hundreds;
  logic        leap;
  logic [4:0]  dim;
  logic        ok_nxt;
  logic [12:0] leap_days;
  date_num_t   conv_nxt;

  always_comb begin
    hundreds  = 15'(qy_a_r) * 15'd100;
    leap      = (y_a_r[1:0] == 2'd0) &&
                ((hundreds != {1'b0, y_a_r}) || (qy_a_r[1:0] == 2'd0));
    dim       = days_in_month(m_a_r, leap);
    ok_nxt    = (y_a_r != 14'd0) && (y_a_r <= 14'(MAX_YEAR)) &&
                (dim != 5'd0) && (d_a_r != 5'd0) && (d_a_r <= dim);
    // Leap days up to the year: y/4 - y/100 + y/400.
    leap_days = 13'(yy_a_r[13:2]) - 13'(qyy_a_r) + 13'(qyy_a_r[7:2]);
    conv_nxt.ok        = ok_nxt;
    conv_nxt.year_days = 23'(yy_a_r) * 23'd365;
    conv_nxt.rest_days = leap_days + 13'(month_offset(mi_a_r)) + 13'(d_a_r);
  end

  always_ff @(posedge clk) begin
    if (en.b) begin
      conv_r <= conv_nxt;
    end
  end

endmodule

// ===== src/gregorian_day_difference_unit.sv =====
// ----------------------------------------------------------------------------
// gregorian_day_difference_unit: signed day count between two Gregorian dates
// Throughput: one item per cycle unless the output stalls; each of the five
// register stages advances on its own, so a stage fills its bubble even
// while the output is held.
// Reset: rst_n (synchronous, active low) clears every stage valid bit;
// the data registers are not reset.
// ----------------------------------------------------------------------------
module gregorian_day_difference_unit import gdd_pkg::*; #(
  parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Pipeline overview:
  //   A: year split, the two divisions by 100 (in the converters)
  //   B: date check, year term 365*y and the leap/month/day remainder
  //   C: full day number of each date
  //   D: raw difference second minus first
  //   E: end-day adjustment, saturation and invalid forcing (output register)
  // Each stage takes a new item when it is empty or its successor moves on,
  // so a stalled output only stops the stages that are actually full.

  logic v_a_r, v_b_r, v_c_r, v_d_r, out_valid_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

  assign rdy_e    = !out_valid_r || out_ready;
  assign rdy_d    = !v_d_r || rdy_e;
  assign rdy_c    = !v_c_r || rdy_d;
  assign rdy_b    = !v_b_r || rdy_c;
  assign rdy_a    = !v_a_r || rdy_b;
  assign in_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r       <= 1'b0;
      v_b_r       <= 1'b0;
      v_c_r       <= 1'b0;
      v_d_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy_a) v_a_r       <= in_valid;
      if (rdy_b) v_b_r       <= v_a_r;
      if (rdy_c) v_c_r       <= v_b_r;
      if (rdy_d) v_d_r       <= v_c_r;
      if (rdy_e) out_valid_r <= v_d_r;
    end
  end

  // The end-day flag rides alongside the converters through A and B.
  logic inc_a_r, inc_b_r, inc_c_r, inc_d_r;
  stg_en_t conv_en;
  date_num_t conv1, conv2;

  assign conv_en.a = rdy_a;
  assign conv_en.b = rdy_b;

  gdd_date_conv #(.MAX_YEAR(MAX_YEAR)) u_conv_first (
    .clk    (clk),
    .en     (conv_en),
    .day    (in_data.first_day),
    .month  (in_data.first_month),
    .year   (in_data.first_year),
    .conv_r (conv1)
  );

  gdd_date_conv #(.MAX_YEAR(MAX_YEAR)) u_conv_second (
    .clk    (clk),
    .en     (conv_en),
    .day    (in_data.second_day),
    .month  (in_data.second_month),
    .year   (in_data.second_year),
    .conv_r (conv2)
  );

  always_ff @(posedge clk) begin
    if (rdy_a) inc_a_r <= in_data.include_end_day;
    if (rdy_b) inc_b_r <= inc_a_r;
  end

  // Stage C: complete day numbers. The largest one stays below 2^23.
  logic [22:0] dn1_c_r, dn2_c_r;
  logic        ok_c_r;

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      dn1_c_r <= conv1.year_days + 23'(conv1.rest_days);
      dn2_c_r <= conv2.year_days + 23'(conv2.rest_days);
      ok_c_r  <= conv1.ok && conv2.ok;
      inc_c_r <= inc_b_r;
    end
  end

  // Stage D: raw difference, wide enough for any 14-bit year pair.
  logic signed [24:0] diff_d_r;
  logic               ok_d_r;

  always_ff @(posedge clk) begin
    if (rdy_d) begin
      diff_d_r <= $signed({2'b00, dn2_c_r}) - $signed({2'b00, dn1_c_r});
      ok_d_r   <= ok_c_r;
      inc_d_r  <= inc_c_r;
    end
  end

  // Stage E: counting the end day grows the magnitude by one, so equal
  // dates give +1. Out-of-range results clip to the 23-bit field, and an
  // invalid date forces the difference to zero.
  logic signed [24:0] adj;
  logic signed [24:0] sat;
  out_item_t          out_nxt;
  out_item_t          out_data_r;

  always_comb begin
    adj = diff_d_r;
    if (inc_d_r) begin
      adj = diff_d_r[24] ? diff_d_r - 25'sd1 : diff_d_r + 25'sd1;
    end
    if (adj > DIFF_MAX) begin
      sat = DIFF_MAX;
    end else if (adj < DIFF_MIN) begin
      sat = DIFF_MIN;
    end else begin
      sat = adj;
    end
    out_nxt.day_difference = ok_d_r ? sat[22:0] : 23'sd0;
    out_nxt.date_invalid   = !ok_d_r;
  end

  always_ff @(posedge clk) begin
    if (rdy_e) out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An invalid date always carries a zero difference.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.date_invalid |-> out_data.day_difference == 23'sd0)
    else $error("invalid item with nonzero difference");

  // With the output register empty, every stage can advance, so input is open.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input blocked while output register is empty");

  // An accepted item occupies stage A on the next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_a_r)
    else $error("accepted item lost at stage A");

  // A full stage D that moves on always lands in the output register.
  a_d_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    v_d_r && rdy_e |=> out_valid)
    else $error("item lost between stage D and the output");

endmodule

// ===== tb/gregorian_day_difference_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_day_difference_unit_test: self-checking bench for the day counter
// A queue of date pairs, directed corner cases first and random pairs after,
// is fed through a valid/ready driver with random gaps. A monitor compares
// every result item with a day count that the bench works out on its own
// from the Gregorian calendar rules. The receiver stalls at random, and
// once for a long stretch so that the pipeline fills and backs up.
// ----------------------------------------------------------------------------
module gregorian_day_difference_unit_test;
  import gdd_pkg::*;

  // The bench runs the block at its default upper year.
  localparam int unsigned YEAR_LIMIT = MAX_YEAR_DEF;

  // Bounds of the signed 23-bit difference field.
  localparam longint DIFF_TOP    = 64'sd4194303;
  localparam longint DIFF_BOTTOM = -64'sd4194304;

  // Number of random items after the directed part.
  localparam int RANDOM_ITEMS = 1825;

  // The long receiver hold-off starts once this many items went in.
  localparam int HOLD_AFTER_ITEMS = 400;
  localparam int HOLD_CYCLES      = 300;

  // Cycles without a handshake on either port before the run is called hung.
  localparam int WATCHDOG_LIMIT = 5000;

  // Extra cycles after the last result; the pipeline is five stages deep.
  localparam int DRAIN_CYCLES = 20;

  // One calendar date as the block sees it.
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } cal_date_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Items waiting to be offered, and day counts waiting to come back.
  in_item_t  pending_items[$];
  out_item_t expected_counts[$];

  int  mismatch_count = 0;
  int  items_accepted = 0;
  int  idle_cycles = 0;
  bit  item_taken = 1'b0;

  // Idle bookkeeping of the sender and the receiver.
  int  send_gap = 0;
  int  send_calm = 0;
  int  ready_gap = 0;
  int  ready_calm = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  gregorian_day_difference_unit #(
    .MAX_YEAR (YEAR_LIMIT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Calendar arithmetic of the prediction.
  // --------------------------------------------------------------------------

  // Gregorian leap rule: every fourth year, except centuries not divisible
  // by four hundred.
  function automatic bit is_leap_year(input int unsigned year);
    return (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
  endfunction

  // Length of a month; zero where the month code names no month.
  function automatic int unsigned month_length(input int unsigned month,
                                               input int unsigned year);
    int unsigned len;
    case (month)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = is_leap_year(year) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  function automatic bit date_is_valid(input cal_date_t dt);
    if (dt.year < 1 || dt.year > YEAR_LIMIT) return 1'b0;
    if (dt.month < 1 || dt.month > 12) return 1'b0;
    return (dt.day >= 1) && (dt.day <= month_length(32'(dt.month), 32'(dt.year)));
  endfunction

  // Continuous day count of a valid date. The year is taken to start in
  // March, so the leap day falls at the very end of it and the months
  // before a date follow a simple linear rule.
  function automatic longint serial_day(input cal_date_t dt);
    longint yr;
    longint mo;
    yr = longint'(dt.year);
    mo = longint'(dt.month);
    if (mo < 3) begin
      yr = yr - 1;
      mo = mo + 12;
    end
    return 365 * yr + yr / 4 - yr / 100 + yr / 400 + (153 * (mo - 3) + 2) / 5
           + longint'(dt.day);
  endfunction

  // Expected result item of one input item.
  function automatic out_item_t predict_day_difference(input in_item_t item);
    out_item_t res;
    cal_date_t first_date;
    cal_date_t second_date;
    longint    span;
    first_date  = '{item.first_day, item.first_month, item.first_year};
    second_date = '{item.second_day, item.second_month, item.second_year};
    res = '0;
    if (!date_is_valid(first_date) || !date_is_valid(second_date)) begin
      // Either date bad: flag it and force the count to zero.
      res.date_invalid = 1'b1;
      return res;
    end
    span = serial_day(second_date) - serial_day(first_date);
    // Counting the end day widens the magnitude; equal dates count as +1.
    if (item.include_end_day) begin
      span = (span < 0) ? span - 1 : span + 1;
    end
    if (span > DIFF_TOP) span = DIFF_TOP;
    if (span < DIFF_BOTTOM) span = DIFF_BOTTOM;
    res.day_difference = span[22:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  function automatic in_item_t date_pair(input cal_date_t first_date,
                                         input cal_date_t second_date,
                                         input bit include_end);
    in_item_t item;
    item.first_day       = first_date.day;
    item.first_month     = first_date.month;
    item.first_year      = first_date.year;
    item.second_day      = second_date.day;
    item.second_month    = second_date.month;
    item.second_year     = second_date.year;
    item.include_end_day = include_end;
    return item;
  endfunction

  // A valid date, leaning toward the edges of the year range, century and
  // leap years, and the first and last days of a month.
  function automatic cal_date_t random_valid_date();
    cal_date_t   dt;
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 8) dt.year = 14'($urandom_range(0, 1) ? $urandom_range(1, 3)
                                  : $urandom_range(YEAR_LIMIT - 2, YEAR_LIMIT));
    else if (pick < 16) dt.year = 14'(100 * $urandom_range(1, YEAR_LIMIT / 100));
    else if (pick < 28) dt.year = 14'(4 * $urandom_range(1, YEAR_LIMIT / 4));
    else dt.year = 14'($urandom_range(1, YEAR_LIMIT));
    dt.month = 4'($urandom_range(1, 12));
    len = month_length(32'(dt.month), 32'(dt.year));
    pick = $urandom_range(0, 99);
    if (pick < 20) dt.day = 5'(len);
    else if (pick < 30) dt.day = 5'd1;
    else dt.day = 5'($urandom_range(1, len));
    return dt;
  endfunction

  // Breaks a valid date in one field only.
  function automatic cal_date_t spoil_date(input cal_date_t dt);
    int unsigned len;
    len = month_length(32'(dt.month), 32'(dt.year));
    case ($urandom_range(0, 5))
      0: dt.day = 5'd0;
      1: dt.day = (len < 31) ? 5'($urandom_range(len + 1, 31)) : 5'd0;
      2: dt.month = 4'd0;
      3: dt.month = 4'($urandom_range(13, 15));
      4: dt.year = 14'd0;
      default: dt.year = 14'($urandom_range(YEAR_LIMIT + 1, 16383));
    endcase
    return dt;
  endfunction

  // Idle length between items: mostly none or short, now and then long,
  // with calm stretches of back-to-back traffic.
  function automatic int pick_gap(inout int calm);
    int unsigned pick;
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      calm = $urandom_range(30, 100);
      return 0;
    end
    if (pick < 60) return 0;
    if (pick < 85) return $urandom_range(1, 2);
    if (pick < 96) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus, reset and the end of the run.
  // --------------------------------------------------------------------------
  initial begin
    cal_date_t   date_a;
    cal_date_t   date_b;
    int unsigned mix;

    // Widest span of the calendar, both ways, with and without the end day.
    pending_items.push_back(date_pair('{5'd1, 4'd1, 14'd1}, '{5'd31, 4'd12, 14'd9999}, 1'b0));
    pending_items.push_back(date_pair('{5'd1, 4'd1, 14'd1}, '{5'd31, 4'd12, 14'd9999}, 1'b1));
    pending_items.push_back(date_pair('{5'd31, 4'd12, 14'd9999}, '{5'd1, 4'd1, 14'd1}, 1'b0));
    pending_items.push_back(date_pair('{5'd31, 4'd12, 14'd9999}, '{5'd1, 4'd1, 14'd1}, 1'b1));
    // Equal dates give zero, or one with the end day counted.
    pending_items.push_back(date_pair('{5'd15, 4'd6, 14'd2024}, '{5'd15, 4'd6, 14'd2024}, 1'b0));
    pending_items.push_back(date_pair('{5'd15, 4'd6, 14'd2024}, '{5'd15, 4'd6, 14'd2024}, 1'b1));
    pending_items.push_back(date_pair('{5'd31, 4'd12, 14'd9999}, '{5'd31, 4'd12, 14'd9999}, 1'b1));
    // Leap days: a year divisible by 400 has one, a plain century has not.
    pending_items.push_back(date_pair('{5'd28, 4'd2, 14'd2000}, '{5'd1, 4'd3, 14'd2000}, 1'b0));
    pending_items.push_back(date_pair('{5'd29, 4'd2, 14'd2000}, '{5'd1, 4'd3, 14'd2000}, 1'b1));
    pending_items.push_back(date_pair('{5'd29, 4'd2, 14'd1900}, '{5'd1, 4'd3, 14'd1900}, 1'b0));
    pending_items.push_back(date_pair('{5'd29, 4'd2, 14'd2004}, '{5'd29, 4'd2, 14'd2008}, 1'b0));
    pending_items.push_back(date_pair('{5'd1, 4'd1, 14'd2100}, '{5'd29, 4'd2, 14'd2100}, 1'b0));
    pending_items.push_back(date_pair('{5'd29, 4'd2, 14'd2023}, '{5'd1, 4'd1, 14'd2023}, 1'b1));
    // Day past the end of a 30-day month, and a day of zero.
    pending_items.push_back(date_pair('{5'd31, 4'd4, 14'd2023}, '{5'd1, 4'd5, 14'd2023}, 1'b0));
    pending_items.push_back(date_pair('{5'd0, 4'd5, 14'd2023}, '{5'd1, 4'd5, 14'd2023}, 1'b0));
    // Month codes outside the calendar.
    pending_items.push_back(date_pair('{5'd1, 4'd0, 14'd2023}, '{5'd1, 4'd5, 14'd2023}, 1'b0));
    pending_items.push_back(date_pair('{5'd1, 4'd5, 14'd2023}, '{5'd1, 4'd13, 14'd2023}, 1'b1));
    pending_items.push_back(date_pair('{5'd1, 4'd15, 14'd2023}, '{5'd1, 4'd5, 14'd2023}, 1'b0));
    // Years outside the range, up to every field at all ones.
    pending_items.push_back(date_pair('{5'd1, 4'd1, 14'd0}, '{5'd1, 4'd1, 14'd1}, 1'b0));
    pending_items.push_back(date_pair('{5'd1, 4'd1, 14'd9999}, '{5'd1, 4'd1, 14'd10000}, 1'b0));
    pending_items.push_back('1);
    pending_items.push_back('0);
    // Year boundary, a backward step across a leap day, and a forward step of one day.
    pending_items.push_back(date_pair('{5'd31, 4'd12, 14'd1999}, '{5'd1, 4'd1, 14'd2000}, 1'b1));
    pending_items.push_back(date_pair('{5'd1, 4'd3, 14'd2000}, '{5'd28, 4'd2, 14'd2000}, 1'b1));
    pending_items.push_back(date_pair('{5'd1, 4'd1, 14'd1}, '{5'd2, 4'd1, 14'd1}, 1'b0));

    // Random part: mostly well-formed pairs with random content, the rest
    // pairs with one bad field and raw noise over every bit.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      mix = $urandom_range(0, 99);
      date_a = random_valid_date();
      if (mix < 8) begin
        date_b = date_a;
      end else if (mix < 58) begin
        date_b = random_valid_date();
      end else if (mix < 72) begin
        // Same year, so the month table dominates the count.
        date_b = random_valid_date();
        date_b.year = date_a.year;
        if (date_b.day > month_length(32'(date_b.month), 32'(date_b.year))) begin
          date_b.day = 5'd1;
        end
      end else if (mix < 88) begin
        date_b = random_valid_date();
        if ($urandom_range(0, 1)) date_a = spoil_date(date_a);
        else date_b = spoil_date(date_b);
      end else begin
        date_a = cal_date_t'(23'($urandom()));
        date_b = cal_date_t'(23'($urandom()));
      end
      pending_items.push_back(date_pair(date_a, date_b, 1'($urandom_range(0, 1))));
    end

    // Reset is released on a falling edge, so the driver still sees it low in
    // that step and starts on the following falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait until every item went in and every result came back.
    do begin
      @(posedge clk);
    end while (pending_items.size() != 0 || in_valid || expected_counts.size() != 0);

    // A little longer, so that a stray extra result would still be caught.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: offers the next queued item on the falling edge. The payload
  // only changes once the previous item has been taken.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || item_taken) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        send_gap = pick_gap(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready pattern, plus one long hold-off once enough items
  // went in. The sender keeps offering during it, so the pipeline fills and
  // in_ready has to drop.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!hold_done && items_accepted >= HOLD_AFTER_ITEMS) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap = ready_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      ready_gap = pick_gap(ready_calm);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: on the rising edge, checks an accepted result against the
  // oldest expectation, then records the prediction of an accepted item.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    item_taken = rst_n && in_valid && in_ready;

    if (rst_n && out_valid && out_ready) begin
      if (expected_counts.size() == 0) begin
        $error("result item with none expected: day_difference %0d, date_invalid %0b",
               out_data.day_difference, out_data.date_invalid);
        mismatch_count++;
      end else begin
        want = expected_counts.pop_front();
        if (out_data.day_difference !== want.day_difference) begin
          $error("day_difference: expected %0d, got %0d",
                 want.day_difference, out_data.day_difference);
          mismatch_count++;
        end
        if (out_data.date_invalid !== want.date_invalid) begin
          $error("date_invalid: expected %0b, got %0b",
                 want.date_invalid, out_data.date_invalid);
          mismatch_count++;
        end
      end
    end

    if (item_taken) begin
      expected_counts.push_back(predict_day_difference(in_data));
      items_accepted++;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a run where neither side moves for too long has hung.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
